### rtl/imu_frame_deframer_sequencer_defines.svh
// Assertion macros shared by the deframer RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef IMU_FRAME_DEFRAMER_SEQUENCER_DEFINES_SVH
`define IMU_FRAME_DEFRAMER_SEQUENCER_DEFINES_SVH

// Checked only outside reset
`define IMFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define IMFD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/imfd_pkg.sv
// Shared types, codes and reset constants of the IMU frame deframer.
// No dependencies.
`default_nettype none

package imfd_pkg;

	localparam int FRAME_BYTES = 11;
	// bytes 0..9 are stored, byte 10 (checksum) is the incoming byte
	localparam int WIN_DEPTH   = FRAME_BYTES - 1;
	localparam int FILL_W      = $clog2(FRAME_BYTES);

	localparam logic [7:0]  HEADER_RST  = 8'h55;
	localparam logic [7:0]  TYPE_A_RST  = 8'h51;
	localparam logic [7:0]  TYPE_G_RST  = 8'h52;
	localparam logic [7:0]  TYPE_N_RST  = 8'h53;
	localparam logic [7:0]  TYPE_Q_RST  = 8'h54;
	localparam logic [15:0] TIMEOUT_RST = 16'd800;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		EV_ACCEPT    = 3'd0,
		EV_CSUM_ERR  = 3'd1,
		EV_SEQ_BREAK = 3'd2,
		EV_IGNORED   = 3'd3,
		EV_TIMEOUT   = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		KIND_ACCEL = 2'd0,
		KIND_GYRO  = 2'd1,
		KIND_ANGLE = 2'd2,
		KIND_QUAT  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_HEADER  = 3'd0,
		REG_TYPE_A  = 3'd1,
		REG_TYPE_G  = 3'd2,
		REG_TYPE_N  = 3'd3,
		REG_TYPE_Q  = 3'd4,
		REG_TIMEOUT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  header;
		logic [7:0]  type_accel;
		logic [7:0]  type_gyro;
		logic [7:0]  type_angle;
		logic [7:0]  type_quat;
		logic [15:0] timeout;
	} cfg_t;

	// Candidate frame seen by the sequencer
	typedef struct packed {
		logic               eval;      // window full with header in front
		logic               csum_ok;
		logic [7:0]         type_byte;
		logic signed [15:0] val_x;
		logic signed [15:0] val_y;
		logic signed [15:0] val_z;
		logic signed [15:0] val_w;
	} frame_t;

	typedef struct packed {
		event_t             ev;
		kind_t              kind;
		logic signed [15:0] val_x;
		logic signed [15:0] val_y;
		logic signed [15:0] val_z;
		logic signed [15:0] val_w;
		logic               set_complete;
	} result_t;

endpackage

`default_nettype wire

### rtl/imu_frame_deframer_sequencer.sv
// IMU frame deframer and sequencer.
//
// Input stream: one request per item; tuser selects a received byte (0) or a
// timer tick (1), tdata carries the byte. Output stream: zero or one result
// per request; tuser carries event and kind, tdata the four raw int16 words,
// tlast marks the quaternion frame that completes an accel/gyro/angle/quat set.
// Configuration: APB registers at byte addresses 0x00..0x14 (header byte,
// four type bytes, timeout ticks); reads return the register value.
//
// Timing: an accepted request is registered in the input stage and processed
// once the output register is free or being emptied; its result enters the
// output register at the end of that cycle and tvalid rises with it. One
// request per cycle is sustained while the receiver takes results; the window
// shift, 10-byte checksum adder and type compares are combinational.
// When the receiver stalls, the result holds in the output register and the
// input stage takes one more request; after that tready drops until the
// output is taken.
// Reset: registers return to their defaults, the window empties, the expected
// kind returns to accel and the tick count clears.
`default_nettype none
`include "imu_frame_deframer_sequencer_defines.svh"

module imu_frame_deframer_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  wire logic [0:0]  s_axis_tuser,   // [0] op
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // [15:0] val_x, [31:16] val_y,
	                                         // [47:32] val_z, [63:48] val_w
	output logic [4:0]       m_axis_tuser,   // [2:0] event_res, [4:3] kind
	output logic             m_axis_tlast,   // set_complete
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import imfd_pkg::*;

	cfg_t       cfg_q;
	reg_idx_t   reg_idx;
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	logic       proc;
	logic       step_byte;
	logic       step_tick;
	frame_t     frame;
	result_t    res;
	logic       res_valid;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header     <= HEADER_RST;
			cfg_q.type_accel <= TYPE_A_RST;
			cfg_q.type_gyro  <= TYPE_G_RST;
			cfg_q.type_angle <= TYPE_N_RST;
			cfg_q.type_quat  <= TYPE_Q_RST;
			cfg_q.timeout    <= TIMEOUT_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_HEADER:  cfg_q.header     <= pwdata[7:0];
				REG_TYPE_A:  cfg_q.type_accel <= pwdata[7:0];
				REG_TYPE_G:  cfg_q.type_gyro  <= pwdata[7:0];
				REG_TYPE_N:  cfg_q.type_angle <= pwdata[7:0];
				REG_TYPE_Q:  cfg_q.type_quat  <= pwdata[7:0];
				REG_TIMEOUT: cfg_q.timeout    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HEADER:  prdata = 32'(cfg_q.header);
			REG_TYPE_A:  prdata = 32'(cfg_q.type_accel);
			REG_TYPE_G:  prdata = 32'(cfg_q.type_gyro);
			REG_TYPE_N:  prdata = 32'(cfg_q.type_angle);
			REG_TYPE_Q:  prdata = 32'(cfg_q.type_quat);
			REG_TIMEOUT: prdata = 32'(cfg_q.timeout);
			default:     prdata = '0;
		endcase
	end

	// Handshake: process when the output slot is free or being emptied
	assign proc          = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || proc;
	assign step_byte     = proc && (op_s1 == OP_BYTE);
	assign step_tick     = proc && (op_s1 == OP_TICK);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1   <= op_t'(s_axis_tuser[0]);
			byte_s1 <= s_axis_tdata;
		end
	end

	imfd_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step_byte),
		.rx_byte (byte_s1),
		.header  (cfg_q.header),
		.frame   (frame)
	);

	imfd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_byte (step_byte),
		.step_tick (step_tick),
		.frame     (frame),
		.cfg       (cfg_q),
		.res       (res),
		.res_valid (res_valid)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (proc) begin
			valid_s2 <= res_valid;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.val_w, res_s2.val_z, res_s2.val_y, res_s2.val_x};
	assign m_axis_tuser  = {res_s2.kind, res_s2.ev};
	assign m_axis_tlast  = res_s2.set_complete;

	`IMFD_ASSERT_ALWAYS(a_stall_has_item, (!s_axis_tready |-> valid_s1), "input stalled while empty")
	`IMFD_ASSERT(a_stage_drains, (proc && !s_axis_tvalid) |=> !valid_s1, "input stage kept a done request")
	`IMFD_ASSERT(a_timeout_no_words, (m_axis_tvalid && (res_s2.ev == EV_TIMEOUT)) |-> (m_axis_tdata == '0), "timeout result carries words")
	`IMFD_ASSERT(a_last_is_quat, (m_axis_tvalid && m_axis_tlast) |-> ((res_s2.ev == EV_ACCEPT) && (res_s2.kind == KIND_QUAT)), "set complete on wrong result")

endmodule

`default_nettype wire

### rtl/imfd_window.sv
// Sliding byte window with header match and additive checksum.
// Depends on imfd_pkg and the shared assertion macros.
`default_nettype none
`include "imu_frame_deframer_sequencer_defines.svh"

module imfd_window (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,      // one received byte is processed
	input  wire logic [7:0]      rx_byte,
	input  wire logic [7:0]      header,
	output imfd_pkg::frame_t     frame
);
	import imfd_pkg::*;

	logic [7:0]        win_q [WIN_DEPTH];
	logic [7:0]        win_n [WIN_DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_n;
	logic              full;
	logic              hdr_ok;
	logic              csum_ok;
	logic [7:0]        sum;

	// Frame check: the incoming byte is the eleventh one
	always_comb begin
		sum = '0;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			sum = sum + win_q[i];
		end
	end

	assign full    = (fill_q == FILL_W'(WIN_DEPTH));
	assign hdr_ok  = (win_q[0] == header);
	assign csum_ok = (sum == rx_byte);

	assign frame.eval      = full && hdr_ok;
	assign frame.csum_ok   = csum_ok;
	assign frame.type_byte = win_q[1];
	assign frame.val_x     = {win_q[3], win_q[2]};
	assign frame.val_y     = {win_q[5], win_q[4]};
	assign frame.val_z     = {win_q[7], win_q[6]};
	assign frame.val_w     = {win_q[9], win_q[8]};

	// Next window: append, empty after a good frame, else drop the oldest
	always_comb begin
		win_n  = win_q;
		fill_n = fill_q;
		if (step) begin
			if (!full) begin
				for (int i = 0; i < WIN_DEPTH; i++) begin
					if (fill_q == FILL_W'(i)) begin
						win_n[i] = rx_byte;
					end
				end
				fill_n = fill_q + FILL_W'(1);
			end else if (hdr_ok && csum_ok) begin
				fill_n = '0;
			end else begin
				for (int i = 0; i < WIN_DEPTH - 1; i++) begin
					win_n[i] = win_q[i + 1];
				end
				win_n[WIN_DEPTH - 1] = rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_n;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_n;
	end

	`IMFD_ASSERT(a_fill_range, (fill_q <= FILL_W'(WIN_DEPTH)), "window fill out of range")
	`IMFD_ASSERT(a_fill_inc, (step && !full) |=> (fill_q == $past(fill_q) + 1'b1), "fill did not advance")
	`IMFD_ASSERT(a_fill_clear, (step && full && hdr_ok && csum_ok) |=> (fill_q == '0), "good frame left bytes")
	`IMFD_ASSERT(a_fill_hold, (step && full && !(hdr_ok && csum_ok)) |=> (fill_q == $past(fill_q)), "drop changed fill")

endmodule

`default_nettype wire

### rtl/imfd_seq.sv
// Frame order tracker: expected kind, tick timeout and result build.
// Depends on imfd_pkg.
`default_nettype none

module imfd_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step_byte,
	input  wire logic             step_tick,
	input  wire imfd_pkg::frame_t frame,
	input  wire imfd_pkg::cfg_t   cfg,
	output imfd_pkg::result_t     res,
	output logic                  res_valid
);
	import imfd_pkg::*;

	kind_t       exp_q;
	kind_t       exp_n;
	logic [15:0] tick_q;
	logic [15:0] tick_n;
	logic [15:0] tick_inc;
	logic [7:0]  exp_type;
	logic        m_a;
	logic        m_g;
	logic        m_n;
	logic        m_q;

	// Type byte of the kind expected next
	always_comb begin
		case (exp_q)
			KIND_ACCEL: exp_type = cfg.type_accel;
			KIND_GYRO:  exp_type = cfg.type_gyro;
			KIND_ANGLE: exp_type = cfg.type_angle;
			KIND_QUAT:  exp_type = cfg.type_quat;
			default:    exp_type = cfg.type_quat;
		endcase
	end

	assign m_a      = (frame.type_byte == cfg.type_accel);
	assign m_g      = (frame.type_byte == cfg.type_gyro);
	assign m_n      = (frame.type_byte == cfg.type_angle);
	assign m_q      = (frame.type_byte == cfg.type_quat);
	assign tick_inc = tick_q + 16'd1;

	// Result and next order state
	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		exp_n     = exp_q;
		tick_n    = tick_q;
		if (step_tick) begin
			if (tick_inc >= cfg.timeout) begin
				tick_n = '0;
				if (exp_q != KIND_ACCEL) begin
					exp_n     = KIND_ACCEL;
					res_valid = 1'b1;
					res.ev    = EV_TIMEOUT;
					res.kind  = exp_q;
				end
			end else begin
				tick_n = tick_inc;
			end
		end else if (step_byte && frame.eval) begin
			res_valid = 1'b1;
			if (!frame.csum_ok) begin
				res.ev = EV_CSUM_ERR;
			end else begin
				res.val_x = frame.val_x;
				res.val_y = frame.val_y;
				res.val_z = frame.val_z;
				res.val_w = frame.val_w;
				if (frame.type_byte == exp_type) begin
					res.ev           = EV_ACCEPT;
					res.kind         = exp_q;
					res.set_complete = (exp_q == KIND_QUAT);
					exp_n            = kind_t'(2'(exp_q + 2'd1));
					tick_n           = '0;
				end else if (m_a || m_g || m_n || m_q) begin
					res.ev = EV_SEQ_BREAK;
					if (m_a) begin
						res.kind = KIND_ACCEL;
					end else if (m_g) begin
						res.kind = KIND_GYRO;
					end else if (m_n) begin
						res.kind = KIND_ANGLE;
					end else begin
						res.kind = KIND_QUAT;
					end
					exp_n = KIND_ACCEL;
				end else begin
					res.ev   = EV_IGNORED;
					res.kind = KIND_ACCEL;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= KIND_ACCEL;
			tick_q <= '0;
		end else begin
			exp_q  <= exp_n;
			tick_q <= tick_n;
		end
	end

endmodule

`default_nettype wire

### dv/imfd_result_checker.sv
// Result checker for the IMU frame deframer: watches the input, result and APB channels.
// Predicts each result from its own copy of the window, sequence and tick state.
// Depends on imfd_pkg.
`timescale 1ns / 1ps

module imfd_result_checker
	import imfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_axis_tuser,   // [0] op
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,   // [15:0] val_x, [31:16] val_y, [47:32] val_z, [63:48] val_w
	input  logic [4:0]  m_axis_tuser,   // [2:0] event_res, [4:3] kind
	input  logic        m_axis_tlast,   // set_complete
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	// configuration copy
	logic [7:0]  hdr_byte;
	logic [7:0]  type_of [4];
	logic [15:0] tick_limit;

	// deframer and sequencer state
	logic [7:0]  win_bytes [FRAME_BYTES];
	int          win_cnt;
	kind_t       want_kind;
	logic [15:0] tick_cnt;

	result_t     pending_results [$];

	// drop the oldest window byte
	function automatic void shift_window();
		for (int i = 0; i < FRAME_BYTES - 1; i++)
			win_bytes[i] = win_bytes[i + 1];
		win_bytes[FRAME_BYTES - 1] = '0;
		if (win_cnt > 0)
			win_cnt--;
	endfunction

	// one request through the deframer; returns 1 when it yields a result
	function automatic bit deframe_step(input op_t op, input logic [7:0] rx, output result_t res);
		logic [7:0] sum;
		logic [7:0] typ;
		kind_t      k;
		res = '0;
		if (op == OP_TICK) begin
			tick_cnt = tick_cnt + 16'd1;
			if (tick_cnt >= tick_limit) begin
				tick_cnt = '0;
				if (want_kind != KIND_ACCEL) begin
					res.ev   = EV_TIMEOUT;
					res.kind = want_kind;
					want_kind = KIND_ACCEL;
					return 1'b1;
				end
			end
			return 1'b0;
		end

		win_bytes[win_cnt] = rx;
		win_cnt++;
		if (win_cnt < FRAME_BYTES)
			return 1'b0;

		// full window without header: slide silently
		if (win_bytes[0] != hdr_byte) begin
			shift_window();
			return 1'b0;
		end

		sum = '0;
		for (int i = 0; i < FRAME_BYTES - 1; i++)
			sum = sum + win_bytes[i];
		if (sum != win_bytes[FRAME_BYTES - 1]) begin
			shift_window();
			res.ev = EV_CSUM_ERR;
			return 1'b1;
		end

		typ = win_bytes[1];
		res.val_x = {win_bytes[3], win_bytes[2]};
		res.val_y = {win_bytes[5], win_bytes[4]};
		res.val_z = {win_bytes[7], win_bytes[6]};
		res.val_w = {win_bytes[9], win_bytes[8]};
		if (typ == type_of[want_kind]) begin
			// expected kind wins even when type registers are equal
			res.ev = EV_ACCEPT;
			res.kind = want_kind;
			res.set_complete = (want_kind == KIND_QUAT);
			want_kind = kind_t'(2'(want_kind + 2'd1));
			tick_cnt = '0;
		end else if (typ == type_of[KIND_ACCEL] || typ == type_of[KIND_GYRO] ||
			     typ == type_of[KIND_ANGLE] || typ == type_of[KIND_QUAT]) begin
			k = KIND_QUAT;
			for (int j = 3; j >= 0; j--)
				if (typ == type_of[j])
					k = kind_t'(j);
			res.ev = EV_SEQ_BREAK;
			res.kind = k;
			want_kind = KIND_ACCEL;
		end else begin
			res.ev = EV_IGNORED;
			res.kind = KIND_ACCEL;
		end

		for (int i = 0; i < FRAME_BYTES; i++)
			win_bytes[i] = '0;
		win_cnt = 0;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// compare results, predict requests, track register writes
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t got;
		bit      has_res;
		if (!arst_n) begin
			hdr_byte = HEADER_RST;
			type_of[KIND_ACCEL] = TYPE_A_RST;
			type_of[KIND_GYRO]  = TYPE_G_RST;
			type_of[KIND_ANGLE] = TYPE_N_RST;
			type_of[KIND_QUAT]  = TYPE_Q_RST;
			tick_limit = TIMEOUT_RST;
			for (int i = 0; i < FRAME_BYTES; i++)
				win_bytes[i] = '0;
			win_cnt = 0;
			want_kind = KIND_ACCEL;
			tick_cnt = '0;
			pending_results.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.ev = event_t'(m_axis_tuser[2:0]);
				got.kind = kind_t'(m_axis_tuser[4:3]);
				got.val_x = m_axis_tdata[15:0];
				got.val_y = m_axis_tdata[31:16];
				got.val_z = m_axis_tdata[47:32];
				got.val_w = m_axis_tdata[63:48];
				got.set_complete = m_axis_tlast;
				if (pending_results.size() == 0) begin
					$error("unexpected result: event_res %0d kind %0d",
						m_axis_tuser[2:0], m_axis_tuser[4:3]);
					fail_count++;
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					check_field("event_res", 16'(want.ev), 16'(got.ev));
					check_field("kind", 16'(want.kind), 16'(got.kind));
					check_field("val_x", want.val_x, got.val_x);
					check_field("val_y", want.val_y, got.val_y);
					check_field("val_z", want.val_z, got.val_z);
					check_field("val_w", want.val_w, got.val_w);
					check_field("set_complete", 16'(want.set_complete),
						16'(got.set_complete));
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				has_res = deframe_step(op_t'(s_axis_tuser[0]), s_axis_tdata, want);
				if (has_res)
					pending_results.push_back(want);
			end

			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_HEADER:  hdr_byte = pwdata[7:0];
					REG_TYPE_A:  type_of[KIND_ACCEL] = pwdata[7:0];
					REG_TYPE_G:  type_of[KIND_GYRO] = pwdata[7:0];
					REG_TYPE_N:  type_of[KIND_ANGLE] = pwdata[7:0];
					REG_TYPE_Q:  type_of[KIND_QUAT] = pwdata[7:0];
					REG_TIMEOUT: tick_limit = pwdata[15:0];
					default: ;
				endcase
			end

			pending = pending_results.size();
		end
	end

endmodule

### dv/tb_imu_frame_deframer_sequencer.sv
// Testbench top for the IMU frame deframer: clock, reset, byte/tick requests, APB setup.
// Results are checked by imfd_result_checker; depends on imfd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_imu_frame_deframer_sequencer;
	import imfd_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int QUIET_LO     = 1500;
	localparam int QUIET_HI     = 2300;
	localparam int HOLD_CYCLES  = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
	logic [0:0]  s_axis_tuser;   // [0] op
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // [15:0] val_x, [31:16] val_y, [47:32] val_z, [63:48] val_w
	logic [4:0]  m_axis_tuser;   // [2:0] event_res, [4:3] kind
	logic        m_axis_tlast;   // set_complete
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          pending;
	int          cyc = 0;
	int          items_sent = 0;

	// what the stimulus believes the block is set to
	logic [7:0]  cur_hdr;
	logic [7:0]  cur_type [4];
	int          tick_pct;
	int          next_kind;

	imu_frame_deframer_sequencer DUT (.*);

	imfd_result_checker checker_i (.*);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic bit no_idle();
		return cyc >= QUIET_LO && cyc < QUIET_HI;
	endfunction

	// receiver: random stalls, plus long hold-offs counted here
	initial begin : receiver
		int got;
		int hold_left;
		got = 0;
		hold_left = 0;
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got++;
				if (got == 30 || got == 120)
					hold_left = HOLD_CYCLES;
			end
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (no_idle()) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= 29);
			end
		end
	end

	// one request, held until accepted
	task automatic send_item(input op_t op, input logic [7:0] b);
		@(negedge clk);
		while (!no_idle() && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		if (tick_pct > 0 && $urandom_range(99) < tick_pct)
			send_item(OP_TICK, 8'($urandom));
		send_item(OP_BYTE, b);
	endtask

	// header, type, four LE words, checksum; len < FRAME_BYTES truncates
	task automatic send_frame(input logic [7:0] typ, input logic [63:0] words, input bit good,
				  input int len);
		logic [7:0] fb [FRAME_BYTES];
		logic [7:0] sum;
		fb[0] = cur_hdr;
		fb[1] = typ;
		for (int i = 0; i < 4; i++) begin
			fb[2 + 2 * i] = words[16 * i +: 8];
			fb[3 + 2 * i] = words[16 * i + 8 +: 8];
		end
		sum = '0;
		for (int i = 0; i < FRAME_BYTES - 1; i++)
			sum = sum + fb[i];
		fb[FRAME_BYTES - 1] = good ? sum : sum ^ 8'($urandom_range(1, 255));
		for (int i = 0; i < len; i++)
			send_byte(fb[i]);
	endtask

	function automatic logic [15:0] rand_word();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rand_words();
		return {rand_word(), rand_word(), rand_word(), rand_word()};
	endfunction

	// stop offering, drain results, let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] hdr, input logic [7:0] ta, input logic [7:0] tg,
				  input logic [7:0] tn, input logic [7:0] tq, input logic [15:0] tout);
		wait_idle();
		reg_write(REG_HEADER, {24'd0, hdr});
		reg_write(REG_TYPE_A, {24'd0, ta});
		reg_write(REG_TYPE_G, {24'd0, tg});
		reg_write(REG_TYPE_N, {24'd0, tn});
		reg_write(REG_TYPE_Q, {24'd0, tq});
		reg_write(REG_TIMEOUT, {16'd0, tout});
		cur_hdr = hdr;
		cur_type[KIND_ACCEL] = ta;
		cur_type[KIND_GYRO] = tg;
		cur_type[KIND_ANGLE] = tn;
		cur_type[KIND_QUAT] = tq;
	endtask

	// mostly in-order frames, with breaks, unknown types, bad sums, noise and ticks
	task automatic random_phase(input int n);
		int target;
		int r;
		int k;
		target = items_sent + n;
		while (items_sent < target) begin
			r = $urandom_range(99);
			if (r < 58) begin
				send_frame(cur_type[next_kind], rand_words(), $urandom_range(99) < 88, FRAME_BYTES);
				next_kind = (next_kind + 1) % 4;
			end else if (r < 72) begin
				k = $urandom_range(3);
				send_frame(cur_type[k], rand_words(), $urandom_range(99) < 88, FRAME_BYTES);
				next_kind = (k == next_kind) ? (next_kind + 1) % 4 : 0;
			end else if (r < 86) begin
				send_frame(8'($urandom), rand_words(), $urandom_range(99) < 88, FRAME_BYTES);
			end else if (r < 92) begin
				repeat ($urandom_range(1, 15)) send_byte(8'($urandom));
			end else if (r < 96) begin
				repeat ($urandom_range(1, 12)) send_item(OP_TICK, 8'($urandom));
			end else begin
				send_frame(cur_type[next_kind], rand_words(), 1'b1, $urandom_range(1, 10));
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_pct = 0;
		next_kind = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extreme words accepted, timeout after one tick, bad checksum
		set_config(8'h55, 8'h51, 8'h52, 8'h53, 8'h54, 16'd1);
		send_frame(cur_type[KIND_ACCEL], {16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000}, 1'b1,
			   FRAME_BYTES);
		send_item(OP_TICK, 8'h00);
		send_frame(cur_type[KIND_QUAT], 64'hFFFF_0000_8000_7FFF, 1'b0, FRAME_BYTES);

		// header and types at the low end, short timeout
		tick_pct = 8;
		set_config(8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 16'd7);
		random_phase(200);

		// high end, longest timeout
		tick_pct = 5;
		set_config(8'hFF, 8'hFF, 8'hFE, 8'h80, 8'h7F, 16'hFFFF);
		random_phase(200);

		// all types equal; timeout lowered below the running count
		tick_pct = 10;
		set_config(8'hA5, 8'h10, 8'h10, 8'h10, 8'h10, 16'd3);
		random_phase(200);

		// zero timeout fires on every tick
		tick_pct = 3;
		set_config(8'h55, 8'h51, 8'h52, 8'h53, 8'h54, 16'd0);
		random_phase(200);

		tick_pct = 8;
		set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			   16'($urandom_range(2, 12)));
		random_phase(200);

		// back to reset values
		tick_pct = 2;
		set_config(HEADER_RST, TYPE_A_RST, TYPE_G_RST, TYPE_N_RST, TYPE_Q_RST, TIMEOUT_RST);
		random_phase(200);

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
